// File: sv/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// shared widths, codes and control types for the task time accounting core
// ----------------------------------------------------------------------------
package nta_pkg;

   // sizes
   localparam int MODELS      = 128;
   localparam int STACK_DEPTH = 256;

   // field widths
   localparam int CMD_W  = 2;
   localparam int ID_W   = 7;
   localparam int CNT_W  = 16;
   localparam int STAT_W = 2;

   // derived widths
   localparam int CNT_AW = (MODELS > 1) ? $clog2(MODELS) : 1;
   localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // controller to datapath
   typedef struct packed {
      logic latch;    // take the request beat
      logic exec;     // stack update, issue counter read
      logic charge;   // counter write back, top reload
      logic fetch;    // issue counter read for the result
      logic load;     // load the result register
   } nta_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } nta_stat_type;

   function automatic logic id_in_range(input logic [ID_W-1:0] id);
      return 32'(id) < MODELS;
   endfunction

   function automatic logic [CNT_AW-1:0] cnt_idx(input logic [ID_W-1:0] id);
      return CNT_AW'(id);
   endfunction

endpackage

// File: sv/nta_ctrl.sv
// ----------------------------------------------------------------------------
// nta_ctrl
// sequencer that steps one beat through the accounting datapath
// ----------------------------------------------------------------------------
module nta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nta_pkg::nta_stat_type sts,
   output nta_pkg::nta_cmd_type  ctl
);
   import nta_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_CHARGE = 3'd2;
   localparam logic [2:0] S_FETCH  = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_EXEC;
         S_EXEC:   state_in = S_CHARGE;
         S_CHARGE: state_in = S_FETCH;
         S_FETCH:  state_in = S_RESULT;
         S_RESULT: if (sts.out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign ctl.latch  = (state_ff == S_IDLE) && req_valid;
   assign ctl.exec   = (state_ff == S_EXEC);
   assign ctl.charge = (state_ff == S_CHARGE);
   assign ctl.fetch  = (state_ff == S_FETCH);
   assign ctl.load   = (state_ff == S_RESULT) && sts.out_free;

endmodule

// File: sv/nta_dp.sv
// ----------------------------------------------------------------------------
// nta_dp
// preemption stack, tick counter memory and result register
// ----------------------------------------------------------------------------
module nta_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  nta_pkg::nta_cmd_type          ctl,
   output nta_pkg::nta_stat_type         sts,
   input  logic [nta_pkg::CMD_W-1:0]     req_cmd,
   input  logic [nta_pkg::ID_W-1:0]      req_model_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_active,
   output logic [nta_pkg::ID_W-1:0]      rsp_model,
   output logic [nta_pkg::CNT_W-1:0]     rsp_count,
   output logic [nta_pkg::STAT_W-1:0]    rsp_status
);
   import nta_pkg::*;

   // latched request
   logic [CMD_W-1:0]  cmd_ff;
   logic [ID_W-1:0]   id_ff;

   // stack state
   logic [LVL_W-1:0]  level_ff, level_in;
   logic [ID_W-1:0]   top_ff, top_in;
   logic [LVL_W-1:0]  level_dec2;
   logic              stk_we;
   logic              reload_ff, reload_in;
   logic [ID_W-1:0]   stack_mem [STACK_DEPTH];
   logic [ID_W-1:0]   stk_rd_ff;

   // per item control
   logic [STAT_W-1:0] status_ff, status_in;
   logic              charge_en_ff, charge_en_in;
   logic [ID_W-1:0]   charge_id;
   logic [CNT_AW-1:0] cidx_ff;

   // counter memory
   logic [CNT_W-1:0]  cnt_mem [MODELS];
   logic [MODELS-1:0] cnt_vld_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic              cnt_rd_vld_ff;
   logic              cnt_re;
   logic [CNT_AW-1:0] cnt_raddr;
   logic              cnt_we;
   logic [CNT_W-1:0]  cnt_cur;
   logic [ID_W-1:0]   out_id;
   logic              out_ok_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_active_ff;
   logic [ID_W-1:0]   rsp_model_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   assign level_dec2 = level_ff - LVL_W'(2);

   // stack update for the latched command
   always_comb begin
      level_in     = level_ff;
      top_in       = top_ff;
      status_in    = ST_OK;
      charge_en_in = 1'b0;
      charge_id    = top_ff;
      reload_in    = 1'b0;
      stk_we       = 1'b0;
      case (cmd_ff)
         CMD_START: begin
            if (level_ff != LVL_W'(STACK_DEPTH)) begin
               stk_we       = 1'b1;
               top_in       = id_ff;
               level_in     = level_ff + LVL_W'(1);
               charge_id    = id_ff;
               charge_en_in = 1'b1;
            end else begin
               status_in    = ST_OVERFLOW;
               charge_en_in = 1'b1;
            end
         end
         CMD_END: begin
            if (level_ff == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               charge_en_in = 1'b1;
               level_in     = level_ff - LVL_W'(1);
               reload_in    = (level_ff > LVL_W'(1));
            end
         end
         CMD_TICK: begin
            charge_en_in = (level_ff != '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (ctl.exec) begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= req_cmd;
         id_ff  <= req_model_id;
      end
      if (ctl.exec) begin
         top_ff       <= top_in;
         status_ff    <= status_in;
         charge_en_ff <= charge_en_in && id_in_range(charge_id);
         cidx_ff      <= cnt_idx(charge_id);
         reload_ff    <= reload_in;
      end else if (ctl.charge && reload_ff) begin
         top_ff <= stk_rd_ff;
      end
      if (ctl.fetch) begin
         out_ok_ff <= id_in_range(out_id);
      end
   end

   // stack memory, push write and registered read of the entry below top
   always_ff @(posedge clock) begin
      if (ctl.exec && stk_we) begin
         stack_mem[level_ff[STK_AW-1:0]] <= id_ff;
      end
      if (ctl.exec && reload_in) begin
         stk_rd_ff <= stack_mem[level_dec2[STK_AW-1:0]];
      end
   end

   // counter memory, read modify write with saturation
   assign out_id    = (cmd_ff == CMD_READ) ? id_ff : top_ff;
   assign cnt_re    = ctl.exec || ctl.fetch;
   assign cnt_raddr = ctl.exec ? cnt_idx(charge_id) : cnt_idx(out_id);
   assign cnt_cur   = cnt_rd_vld_ff ? cnt_rd_ff : '0;
   assign cnt_we    = ctl.charge && charge_en_ff && (cnt_cur != CNT_MAX);

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cidx_ff] <= cnt_cur + CNT_W'(1);
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff    <= '0;
         cnt_rd_vld_ff <= 1'b0;
      end else begin
         if (cnt_we) begin
            cnt_vld_ff[cidx_ff] <= 1'b1;
         end
         if (cnt_re) begin
            cnt_rd_vld_ff <= cnt_vld_ff[cnt_raddr];
         end
      end
   end

   // result register
   assign rsp_valid_in = ctl.load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_active_ff <= (level_ff != '0);
         rsp_status_ff <= status_ff;
         if ((cmd_ff == CMD_READ) || (level_ff != '0)) begin
            rsp_model_ff <= out_id;
            rsp_count_ff <= (out_ok_ff && cnt_rd_vld_ff) ? cnt_rd_ff : '0;
         end else begin
            rsp_model_ff <= '0;
            rsp_count_ff <= '0;
         end
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_active   = rsp_active_ff;
   assign rsp_model    = rsp_model_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_status   = rsp_status_ff;

   // stack never holds more than its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(STACK_DEPTH))
      else $error("stack level beyond depth");

   // stack level moves only in the execute step
   a_level_step: assert property (@(posedge clock) disable iff (reset)
      !ctl.exec |=> $stable(level_ff))
      else $error("stack level changed outside execute");

   // a loaded result is presented next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> rsp_valid_ff)
      else $error("result lost after load");

   // an end on an empty stack leaves nothing running
   a_under_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_UNDERFLOW)) |-> !rsp_active_ff)
      else $error("underflow result reports a running model");

endmodule

// File: sv/nested_task_time_accounting_core.sv
// ----------------------------------------------------------------------------
// nested_task_time_accounting_core
// per model tick accounting over a preemption stack of running models
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   req_cmd, req_model_id
//   rsp_      out        rsp_valid / rsp_ready   rsp_active, rsp_model,
//                                                rsp_count, rsp_status
//
// each request beat steps through accept, stack update with the counter
// read, counter write back with the top reload, counter read for the result,
// result load; the counter memory has a single read port and is read twice
// per beat; the result register is separate, so a finished beat waits there
// while the next request is accepted; a stalled rsp_ready holds the sequencer
// in the load step only
// synchronous reset empties the stack and marks every counter as zero through
// per entry valid bits, with no clearing pass
//
module nested_task_time_accounting_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nta_pkg::CMD_W-1:0]     req_cmd,
   input  logic [nta_pkg::ID_W-1:0]      req_model_id,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_active,
   output logic [nta_pkg::ID_W-1:0]      rsp_model,
   output logic [nta_pkg::CNT_W-1:0]     rsp_count,
   output logic [nta_pkg::STAT_W-1:0]    rsp_status
);
   import nta_pkg::*;

   // command and status between sequencer and datapath
   nta_cmd_type  ctl;
   nta_stat_type sts;

   // sequencer: one beat at a time through the datapath steps
   nta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // datapath: stack memory, counter memory, result register
   nta_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sts          (sts),
      .req_cmd      (req_cmd),
      .req_model_id (req_model_id),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_active   (rsp_active),
      .rsp_model    (rsp_model),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status)
   );

endmodule
